FILE: sv/cfq_pkg.sv
// Shared types and constants for the per-class credit FIFO.
package cfq_pkg;

  localparam int unsigned NumClassesDef = 63;
  localparam int unsigned PoolDepthDef  = 1024;

  localparam int unsigned OpW     = 2;
  localparam int unsigned ClassW  = 6;
  localparam int unsigned CreditW = 16;
  localparam int unsigned IdW     = 31;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_SET_CREDIT = 2'd0,
    OP_ENQUEUE    = 2'd1,
    OP_POP        = 2'd2,
    OP_RSVD       = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_CLASS = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET,
    S_ENQ_RD,
    S_ENQ_WR,
    S_POP_RD,
    S_POP_RD2,
    S_POP_WR,
    S_RESP
  } seq_state_e;

  typedef struct packed {
    logic [OpW-1:0]     op;
    logic [ClassW-1:0]  class_num;
    logic [CreditW-1:0] credit_count;
    logic [IdW-1:0]     item_id;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     out_id;
    logic [ClassW-1:0]  out_class;
    logic               granted;
  } out_item_t;

  typedef struct packed {
    logic rd_en;
    logic head_we;
    logic tail_we;
    logic credit_we;
    logic set_ne;
    logic clr_ne;
  } cls_ctl_t;

  typedef struct packed {
    logic rd_en;
    logic link_we;
    logic value_we;
  } pool_ctl_t;

endpackage

FILE: sv/cfq_class_tbl.sv
// Per-class head, tail, credit and non-empty tables with a registered lowest-class finder.
module cfq_class_tbl #(
  parameter int unsigned NUM_CLASSES = cfq_pkg::NumClassesDef,
  parameter int unsigned PTR_W       = 10,
  localparam int unsigned CIDX_W     = $clog2(NUM_CLASSES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfq_pkg::cls_ctl_t           ctl_i,
  input  logic [CIDX_W-1:0]           idx_i,
  input  logic [PTR_W-1:0]            head_wdata_i,
  input  logic [PTR_W-1:0]            tail_wdata_i,
  input  logic [cfq_pkg::CreditW-1:0] credit_wdata_i,
  output logic [PTR_W-1:0]            head_rdata_o,
  output logic [PTR_W-1:0]            tail_rdata_o,
  output logic [cfq_pkg::CreditW-1:0] credit_rdata_o,
  output logic                        ne_rdata_o,
  output logic                        first_vld_o,
  output logic [CIDX_W-1:0]           first_idx_o
);

  logic [PTR_W-1:0]            head_mem [NUM_CLASSES];
  logic [PTR_W-1:0]            tail_mem [NUM_CLASSES];
  logic [cfq_pkg::CreditW-1:0] credit_mem [NUM_CLASSES];

  logic [NUM_CLASSES-1:0]      credit_vld_q;
  logic [NUM_CLASSES-1:0]      ne_q;

  logic [PTR_W-1:0]            head_rd_q;
  logic [PTR_W-1:0]            tail_rd_q;
  logic [cfq_pkg::CreditW-1:0] credit_rd_q;
  logic                        credit_vld_rd_q;
  logic                        ne_rd_q;

  logic                        first_vld_d, first_vld_q;
  logic [CIDX_W-1:0]           first_idx_d, first_idx_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.head_we) begin
      head_mem[idx_i] <= head_wdata_i;
    end
    if (ctl_i.tail_we) begin
      tail_mem[idx_i] <= tail_wdata_i;
    end
    if (ctl_i.credit_we) begin
      credit_mem[idx_i] <= credit_wdata_i;
    end
    if (ctl_i.rd_en) begin
      head_rd_q   <= head_mem[idx_i];
      tail_rd_q   <= tail_mem[idx_i];
      credit_rd_q <= credit_mem[idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      credit_vld_q    <= '0;
      ne_q            <= '0;
      credit_vld_rd_q <= 1'b0;
      ne_rd_q         <= 1'b0;
      first_vld_q     <= 1'b0;
      first_idx_q     <= '0;
    end else begin
      if (ctl_i.credit_we) begin
        credit_vld_q[idx_i] <= 1'b1;
      end
      if (ctl_i.set_ne) begin
        ne_q[idx_i] <= 1'b1;
      end else if (ctl_i.clr_ne) begin
        ne_q[idx_i] <= 1'b0;
      end
      if (ctl_i.rd_en) begin
        credit_vld_rd_q <= credit_vld_q[idx_i];
        ne_rd_q         <= ne_q[idx_i];
      end
      first_vld_q <= first_vld_d;
      first_idx_q <= first_idx_d;
    end
  end

  always_comb begin
    first_vld_d = 1'b0;
    first_idx_d = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (ne_q[i]) begin
        first_vld_d = 1'b1;
        first_idx_d = CIDX_W'(i);
      end
    end
  end

  assign head_rdata_o   = head_rd_q;
  assign tail_rdata_o   = tail_rd_q;
  assign credit_rdata_o = credit_vld_rd_q ? credit_rd_q : '0;
  assign ne_rdata_o     = ne_rd_q;
  assign first_vld_o    = first_vld_q;
  assign first_idx_o    = first_idx_q;

endmodule

FILE: sv/cfq_node_pool.sv
// Shared node pool: link and value memories with registered reads.
module cfq_node_pool #(
  parameter int unsigned POOL_DEPTH = cfq_pkg::PoolDepthDef,
  localparam int unsigned PTR_W     = $clog2(POOL_DEPTH)
) (
  input  logic                    clk_i,
  input  cfq_pkg::pool_ctl_t      ctl_i,
  input  logic [PTR_W-1:0]        rd_addr_i,
  input  logic [PTR_W-1:0]        link_waddr_i,
  input  logic [PTR_W-1:0]        link_wdata_i,
  input  logic [PTR_W-1:0]        value_waddr_i,
  input  logic [cfq_pkg::IdW-1:0] value_wdata_i,
  output logic [PTR_W-1:0]        link_rdata_o,
  output logic [cfq_pkg::IdW-1:0] value_rdata_o
);

  logic [PTR_W-1:0]        link_mem  [POOL_DEPTH];
  logic [cfq_pkg::IdW-1:0] value_mem [POOL_DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.link_we) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    if (ctl_i.value_we) begin
      value_mem[value_waddr_i] <= value_wdata_i;
    end
    if (ctl_i.rd_en) begin
      link_rdata_o  <= link_mem[rd_addr_i];
      value_rdata_o <= value_mem[rd_addr_i];
    end
  end

endmodule

FILE: sv/cfq_seq.sv
// Operation sequencer: free-list state, table and pool access steps, result register.
module cfq_seq #(
  parameter int unsigned NUM_CLASSES = cfq_pkg::NumClassesDef,
  parameter int unsigned POOL_DEPTH  = cfq_pkg::PoolDepthDef,
  localparam int unsigned PTR_W      = $clog2(POOL_DEPTH),
  localparam int unsigned CNT_W      = $clog2(POOL_DEPTH + 1),
  localparam int unsigned CIDX_W     = $clog2(NUM_CLASSES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  cfq_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output cfq_pkg::out_item_t          out_item_o,
  output cfq_pkg::cls_ctl_t           cls_ctl_o,
  output logic [CIDX_W-1:0]           cls_idx_o,
  output logic [PTR_W-1:0]            head_wdata_o,
  output logic [PTR_W-1:0]            tail_wdata_o,
  output logic [cfq_pkg::CreditW-1:0] credit_wdata_o,
  input  logic [PTR_W-1:0]            head_rdata_i,
  input  logic [PTR_W-1:0]            tail_rdata_i,
  input  logic [cfq_pkg::CreditW-1:0] credit_rdata_i,
  input  logic                        ne_rdata_i,
  input  logic                        first_vld_i,
  input  logic [CIDX_W-1:0]           first_idx_i,
  output cfq_pkg::pool_ctl_t          pool_ctl_o,
  output logic [PTR_W-1:0]            pool_rd_addr_o,
  output logic [PTR_W-1:0]            link_waddr_o,
  output logic [PTR_W-1:0]            link_wdata_o,
  output logic [PTR_W-1:0]            value_waddr_o,
  output logic [cfq_pkg::IdW-1:0]     value_wdata_o,
  input  logic [PTR_W-1:0]            link_rdata_i,
  input  logic [cfq_pkg::IdW-1:0]     value_rdata_i
);

  cfq_pkg::seq_state_e state_d, state_q;
  cfq_pkg::in_item_t   in_d, in_q;
  logic [CIDX_W-1:0]   cls_d, cls_q;
  cfq_pkg::out_item_t  res_d, res_q;
  cfq_pkg::out_item_t  out_d, out_q;
  logic                out_valid_d, out_valid_q;
  logic [CNT_W-1:0]    fresh_d, fresh_q;
  logic [PTR_W-1:0]    free_head_d, free_head_q;
  logic [CNT_W-1:0]    free_len_d, free_len_q;

  logic                cls_ok;
  logic                use_free;
  logic                pool_full;
  logic [PTR_W-1:0]    new_node;
  logic                out_free;

  assign cls_ok    = (in_item_i.class_num != '0) &&
                     (in_item_i.class_num <= cfq_pkg::ClassW'(NUM_CLASSES));
  assign use_free  = (free_len_q != '0);
  assign pool_full = !use_free && (fresh_q == CNT_W'(POOL_DEPTH));
  assign new_node  = use_free ? free_head_q : fresh_q[PTR_W-1:0];
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cfq_pkg::S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_item_i.op)
            cfq_pkg::OP_SET_CREDIT: state_d = cls_ok ? cfq_pkg::S_SET : cfq_pkg::S_RESP;
            cfq_pkg::OP_ENQUEUE:    state_d = cls_ok ? cfq_pkg::S_ENQ_RD : cfq_pkg::S_RESP;
            cfq_pkg::OP_POP:        state_d = first_vld_i ? cfq_pkg::S_POP_RD : cfq_pkg::S_RESP;
            default:                state_d = cfq_pkg::S_RESP;
          endcase
        end
      end
      cfq_pkg::S_SET:     state_d = cfq_pkg::S_RESP;
      cfq_pkg::S_ENQ_RD:  state_d = pool_full ? cfq_pkg::S_RESP : cfq_pkg::S_ENQ_WR;
      cfq_pkg::S_ENQ_WR:  state_d = cfq_pkg::S_RESP;
      cfq_pkg::S_POP_RD:  state_d = cfq_pkg::S_POP_RD2;
      cfq_pkg::S_POP_RD2: state_d = cfq_pkg::S_POP_WR;
      cfq_pkg::S_POP_WR:  state_d = cfq_pkg::S_RESP;
      cfq_pkg::S_RESP: begin
        if (out_free) begin
          state_d = cfq_pkg::S_IDLE;
        end
      end
      default: state_d = cfq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_d           = in_q;
    cls_d          = cls_q;
    res_d          = res_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    fresh_d        = fresh_q;
    free_head_d    = free_head_q;
    free_len_d     = free_len_q;
    cls_ctl_o      = '0;
    pool_ctl_o     = '0;
    head_wdata_o   = new_node;
    tail_wdata_o   = new_node;
    credit_wdata_o = in_q.credit_count;
    pool_rd_addr_o = free_head_q;
    link_waddr_o   = tail_rdata_i;
    link_wdata_o   = new_node;
    value_waddr_o  = new_node;
    value_wdata_o  = in_q.item_id;
    in_ready_o     = 1'b0;

    unique case (state_q)
      cfq_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          in_d  = in_item_i;
          cls_d = CIDX_W'(in_item_i.class_num - cfq_pkg::ClassW'(1));
          res_d = '0;
          unique case (in_item_i.op)
            cfq_pkg::OP_SET_CREDIT, cfq_pkg::OP_ENQUEUE: begin
              if (!cls_ok) begin
                res_d.status = cfq_pkg::ST_BAD_CLASS;
              end
            end
            cfq_pkg::OP_POP: begin
              cls_d = first_idx_i;
              if (!first_vld_i) begin
                res_d.status = cfq_pkg::ST_EMPTY;
              end
            end
            default: res_d.status = cfq_pkg::ST_BAD_CLASS;
          endcase
        end
      end
      cfq_pkg::S_SET: begin
        cls_ctl_o.credit_we = 1'b1;
      end
      cfq_pkg::S_ENQ_RD: begin
        cls_ctl_o.rd_en  = 1'b1;
        pool_ctl_o.rd_en = 1'b1;
        if (pool_full) begin
          res_d.status = cfq_pkg::ST_FULL;
        end
      end
      cfq_pkg::S_ENQ_WR: begin
        pool_ctl_o.value_we = 1'b1;
        pool_ctl_o.link_we  = ne_rdata_i;
        cls_ctl_o.head_we   = !ne_rdata_i;
        cls_ctl_o.tail_we   = 1'b1;
        cls_ctl_o.set_ne    = 1'b1;
        if (use_free) begin
          free_head_d = link_rdata_i;
          free_len_d  = free_len_q - CNT_W'(1);
        end else begin
          fresh_d = fresh_q + CNT_W'(1);
        end
      end
      cfq_pkg::S_POP_RD: begin
        cls_ctl_o.rd_en = 1'b1;
      end
      cfq_pkg::S_POP_RD2: begin
        pool_ctl_o.rd_en = 1'b1;
        pool_rd_addr_o   = head_rdata_i;
      end
      cfq_pkg::S_POP_WR: begin
        res_d.out_id    = value_rdata_i;
        res_d.out_class = cfq_pkg::ClassW'(cls_q) + cfq_pkg::ClassW'(1);
        head_wdata_o    = link_rdata_i;
        if (tail_rdata_i == head_rdata_i) begin
          cls_ctl_o.clr_ne = 1'b1;
        end else begin
          cls_ctl_o.head_we = 1'b1;
        end
        pool_ctl_o.link_we = 1'b1;
        link_waddr_o       = head_rdata_i;
        link_wdata_o       = free_head_q;
        free_head_d        = head_rdata_i;
        free_len_d         = free_len_q + CNT_W'(1);
        credit_wdata_o     = credit_rdata_i - cfq_pkg::CreditW'(1);
        if (credit_rdata_i != '0) begin
          cls_ctl_o.credit_we = 1'b1;
          res_d.granted       = 1'b1;
        end
      end
      cfq_pkg::S_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cfq_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      fresh_q     <= '0;
      free_head_q <= '0;
      free_len_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      fresh_q     <= fresh_d;
      free_head_q <= free_head_d;
      free_len_q  <= free_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    cls_q <= cls_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign cls_idx_o   = cls_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_free_within_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_len_q <= fresh_q)
    else $error("free list longer than nodes handed out");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= CNT_W'(POOL_DEPTH))
    else $error("fresh node count beyond pool depth");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == cfq_pkg::S_RESP))
    else $error("result presented outside response step");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != cfq_pkg::S_IDLE))
    else $error("sequencer idle right after a transfer");
`endif

endmodule

FILE: sv/per_class_fifo_with_credits_top.sv
// Top level of the per-class linked-list FIFO with credit counters.
// Path from transfer to result valid: set credits via S_SET, enqueue via S_ENQ_RD and S_ENQ_WR,
// enqueue into a full pool via S_ENQ_RD only, pop via S_POP_RD, S_POP_RD2, S_POP_WR; bad class,
// empty pop and unused op go straight to S_RESP, which registers the result. One item at a time;
// input ready again in the cycle the result appears; a waiting result not yet taken holds S_RESP.
// Reset (rst_ni, async low) clears queue flags, credit valid bits and free-list state;
// no clearing pass is needed, so items are taken from the first cycle after reset.
module per_class_fifo_with_credits_top #(
  parameter int unsigned NUM_CLASSES = cfq_pkg::NumClassesDef,
  parameter int unsigned POOL_DEPTH  = cfq_pkg::PoolDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cfq_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cfq_pkg::out_item_t out_item_o
);

  localparam int unsigned PtrW  = $clog2(POOL_DEPTH);
  localparam int unsigned CidxW = $clog2(NUM_CLASSES);

  cfq_pkg::cls_ctl_t           cls_ctl;
  cfq_pkg::pool_ctl_t          pool_ctl;
  logic [CidxW-1:0]            cls_idx;
  logic [PtrW-1:0]             head_wdata, tail_wdata, head_rdata, tail_rdata;
  logic [cfq_pkg::CreditW-1:0] credit_wdata, credit_rdata;
  logic                        ne_rdata;
  logic                        first_vld;
  logic [CidxW-1:0]            first_idx;
  logic [PtrW-1:0]             pool_rd_addr, link_waddr, link_wdata, value_waddr;
  logic [PtrW-1:0]             link_rdata;
  logic [cfq_pkg::IdW-1:0]     value_wdata, value_rdata;

  cfq_class_tbl #(
    .NUM_CLASSES (NUM_CLASSES),
    .PTR_W       (PtrW)
  ) u_class_tbl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (cls_ctl),
    .idx_i          (cls_idx),
    .head_wdata_i   (head_wdata),
    .tail_wdata_i   (tail_wdata),
    .credit_wdata_i (credit_wdata),
    .head_rdata_o   (head_rdata),
    .tail_rdata_o   (tail_rdata),
    .credit_rdata_o (credit_rdata),
    .ne_rdata_o     (ne_rdata),
    .first_vld_o    (first_vld),
    .first_idx_o    (first_idx)
  );

  cfq_node_pool #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_node_pool (
    .clk_i         (clk_i),
    .ctl_i         (pool_ctl),
    .rd_addr_i     (pool_rd_addr),
    .link_waddr_i  (link_waddr),
    .link_wdata_i  (link_wdata),
    .value_waddr_i (value_waddr),
    .value_wdata_i (value_wdata),
    .link_rdata_o  (link_rdata),
    .value_rdata_o (value_rdata)
  );

  cfq_seq #(
    .NUM_CLASSES (NUM_CLASSES),
    .POOL_DEPTH  (POOL_DEPTH)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_item_i      (in_item_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_item_o     (out_item_o),
    .cls_ctl_o      (cls_ctl),
    .cls_idx_o      (cls_idx),
    .head_wdata_o   (head_wdata),
    .tail_wdata_o   (tail_wdata),
    .credit_wdata_o (credit_wdata),
    .head_rdata_i   (head_rdata),
    .tail_rdata_i   (tail_rdata),
    .credit_rdata_i (credit_rdata),
    .ne_rdata_i     (ne_rdata),
    .first_vld_i    (first_vld),
    .first_idx_i    (first_idx),
    .pool_ctl_o     (pool_ctl),
    .pool_rd_addr_o (pool_rd_addr),
    .link_waddr_o   (link_waddr),
    .link_wdata_o   (link_wdata),
    .value_waddr_o  (value_waddr),
    .value_wdata_o  (value_wdata),
    .link_rdata_i   (link_rdata),
    .value_rdata_i  (value_rdata)
  );

endmodule
